>>> rtl/core/esh_pkg.sv
`timescale 1ns / 1ps

package esh_pkg;

    localparam int CFG_REGS = 8;
    localparam int CFG_ADDR_BITS = 5;
    localparam int SCALE_FRAC = 20;

    localparam logic [2:0] REG_X_MIN = 3'd0;
    localparam logic [2:0] REG_Y_MIN = 3'd1;
    localparam logic [2:0] REG_X_SCALE = 3'd2;
    localparam logic [2:0] REG_Y_SCALE = 3'd3;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd4;
    localparam logic [2:0] REG_RADIUS_SQ = 3'd5;
    localparam logic [2:0] REG_ACT_WIDTH = 3'd6;
    localparam logic [2:0] REG_ACT_HEIGHT = 3'd7;

    localparam logic signed [31:0] RST_X_MIN = -32'sd536870912;
    localparam logic signed [31:0] RST_Y_MIN = -32'sd402653184;
    localparam logic [31:0] RST_X_SCALE = 32'd89478485;
    localparam logic [31:0] RST_Y_SCALE = 32'd89478485;
    localparam logic [9:0] RST_ITER_LIMIT = 10'd500;
    localparam logic [30:0] RST_RADIUS_SQ = 31'd1073741824;
    localparam logic [8:0] RST_ACT_WIDTH = 9'd256;
    localparam logic [8:0] RST_ACT_HEIGHT = 9'd256;

    localparam logic ACTION_TRACE = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    typedef struct packed {
        logic signed [31:0] x_min;
        logic signed [31:0] y_min;
        logic [31:0] x_scale;
        logic [31:0] y_scale;
        logic [9:0] iter_limit;
        logic [30:0] radius_sq;
        logic [8:0] act_width;
        logic [8:0] act_height;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_STEP,
        ST_RMUL,
        ST_RSTEP,
        ST_BMUL,
        ST_BIN,
        ST_RD,
        ST_WR,
        ST_FIN,
        ST_RRD,
        ST_RFIN
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic mul;
        logic esc_step;
        logic rep_init;
        logic rep_step;
        logic bin_mul;
        logic bin_calc;
        logic mem_wr;
        logic clr;
        logic out_trace;
        logic out_read;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic esc_cont;
        logic escaped;
        logic rep_done;
        logic clr_done;
        logic out_free;
    } t_status;

endpackage

>>> rtl/core/esh_if.sv
`timescale 1ns / 1ps

interface esh_in_if;
    logic valid;
    logic ready;
    logic action;
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
    logic [7:0] bin_x;
    logic [7:0] bin_y;

    modport source (output valid, action, c_re, c_im, bin_x, bin_y, input ready);
    modport sink (input valid, action, c_re, c_im, bin_x, bin_y, output ready);
endinterface

interface esh_out_if;
    logic valid;
    logic ready;
    logic escaped;
    logic [10:0] iterations;
    logic [31:0] bin_count;

    modport source (output valid, escaped, iterations, bin_count, input ready);
    modport sink (input valid, escaped, iterations, bin_count, output ready);
endinterface

>>> rtl/core/esh_regs.sv
`timescale 1ns / 1ps

module esh_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output esh_pkg::t_cfg o_cfg
);
    import esh_pkg::*;

    t_cfg r_cfg;
    logic [2:0] w_idx;
    logic w_wr;

    assign w_idx = paddr[4:2];
    assign w_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_min <= RST_X_MIN;
            r_cfg.y_min <= RST_Y_MIN;
            r_cfg.x_scale <= RST_X_SCALE;
            r_cfg.y_scale <= RST_Y_SCALE;
            r_cfg.iter_limit <= RST_ITER_LIMIT;
            r_cfg.radius_sq <= RST_RADIUS_SQ;
            r_cfg.act_width <= RST_ACT_WIDTH;
            r_cfg.act_height <= RST_ACT_HEIGHT;
        end else if (w_wr) begin
            case (w_idx)
                REG_X_MIN: r_cfg.x_min <= pwdata;
                REG_Y_MIN: r_cfg.y_min <= pwdata;
                REG_X_SCALE: r_cfg.x_scale <= pwdata;
                REG_Y_SCALE: r_cfg.y_scale <= pwdata;
                REG_ITER_LIMIT: r_cfg.iter_limit <= pwdata[9:0];
                REG_RADIUS_SQ: r_cfg.radius_sq <= pwdata[30:0];
                REG_ACT_WIDTH: r_cfg.act_width <= pwdata[8:0];
                REG_ACT_HEIGHT: r_cfg.act_height <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_X_MIN: prdata = r_cfg.x_min;
            REG_Y_MIN: prdata = r_cfg.y_min;
            REG_X_SCALE: prdata = r_cfg.x_scale;
            REG_Y_SCALE: prdata = r_cfg.y_scale;
            REG_ITER_LIMIT: prdata = {22'd0, r_cfg.iter_limit};
            REG_RADIUS_SQ: prdata = {1'b0, r_cfg.radius_sq};
            REG_ACT_WIDTH: prdata = {23'd0, r_cfg.act_width};
            REG_ACT_HEIGHT: prdata = {23'd0, r_cfg.act_height};
            default: prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/core/esh_ctrl.sv
`timescale 1ns / 1ps

module esh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  esh_pkg::t_status i_status,
    output esh_pkg::t_cmd    o_cmd
);
    import esh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_status.is_read ? ST_RRD : ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (i_status.esc_cont) begin
                    o_cmd.esc_step = 1'b1;
                    n_state = ST_MUL;
                end else if (i_status.escaped) begin
                    o_cmd.rep_init = 1'b1;
                    n_state = ST_RMUL;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_RMUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_RSTEP;
            end
            ST_RSTEP: begin
                o_cmd.rep_step = 1'b1;
                n_state = ST_BMUL;
            end
            ST_BMUL: begin
                o_cmd.bin_mul = 1'b1;
                n_state = ST_BIN;
            end
            ST_BIN: begin
                o_cmd.bin_calc = 1'b1;
                n_state = ST_RD;
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                o_cmd.mem_wr = 1'b1;
                n_state = i_status.rep_done ? ST_FIN : ST_RMUL;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_trace = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RRD: begin
                n_state = ST_RFIN;
            end
            ST_RFIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_read = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/esh_datapath.sv
`timescale 1ns / 1ps

module esh_datapath #(
    parameter int GRID_X = 256,
    parameter int GRID_Y = 256,
    parameter int COUNT_BITS = 32,
    parameter int FRAC_BITS = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  esh_pkg::t_cfg      i_cfg,
    input  esh_pkg::t_cmd      i_cmd,
    output esh_pkg::t_status   o_status,
    input  logic               i_action,
    input  logic signed [31:0] i_c_re,
    input  logic signed [31:0] i_c_im,
    input  logic [7:0]         i_bin_x,
    input  logic [7:0]         i_bin_y,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_escaped,
    output logic [10:0]        o_iterations,
    output logic [31:0]        o_bin_count
);
    import esh_pkg::*;

    localparam int DEPTH = GRID_X * GRID_Y;
    localparam int AW = $clog2(DEPTH);
    localparam int XB = $clog2(GRID_X);
    localparam int YB = $clog2(GRID_Y);
    localparam int SH = FRAC_BITS + SCALE_FRAC;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;

    logic signed [31:0] r_cr, r_ci, r_re, r_im;
    logic signed [63:0] r_rr, r_ii, r_ri;
    logic [10:0] r_n, r_k;
    logic [63:0] r_px, r_py;
    logic r_negx, r_negy;
    logic [AW-1:0] r_addr, r_clr_addr;
    logic r_hit, r_oob;
    logic r_out_valid, r_escaped;
    logic [10:0] r_iterations;
    logic [31:0] r_bin_count;

    logic signed [63:0] w_nr, w_ni, w_mag;
    logic signed [31:0] w_re_next, w_im_next;
    logic signed [32:0] w_dx, w_dy;
    logic [32:0] w_mx, w_my;
    logic [63:0] w_qx, w_qy, w_wlim, w_hlim;
    logic w_hit;
    logic [AW-1:0] w_addr;
    logic w_we;
    logic [AW-1:0] w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;
    logic [63:0] w_rd_ext;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    assign w_nr = (r_rr >>> FRAC_BITS) - (r_ii >>> FRAC_BITS) + 64'(r_cr);
    assign w_ni = (r_ri >>> (FRAC_BITS - 1)) + 64'(r_ci);
    assign w_mag = (r_rr >>> FRAC_BITS) + (r_ii >>> FRAC_BITS);
    assign w_re_next = sat32(w_nr);
    assign w_im_next = sat32(w_ni);

    assign w_dx = 33'(r_re) - 33'(i_cfg.x_min);
    assign w_dy = 33'(r_im) - 33'(i_cfg.y_min);
    assign w_mx = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_my = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);

    assign w_qx = r_px >> SH;
    assign w_qy = r_py >> SH;
    assign w_wlim = (int'(i_cfg.act_width) < GRID_X) ? 64'(i_cfg.act_width) : 64'(GRID_X);
    assign w_hlim = (int'(i_cfg.act_height) < GRID_Y) ? 64'(i_cfg.act_height) : 64'(GRID_Y);
    assign w_hit = !(r_negx && w_qx != 64'd0) && (w_qx < w_wlim)
                && !(r_negy && w_qy != 64'd0) && (w_qy < w_hlim);
    assign w_addr = AW'(w_qy[YB-1:0]) * AW'(GRID_X) + AW'(w_qx[XB-1:0]);

    assign w_we = i_cmd.clr || (i_cmd.mem_wr && r_hit && (~r_rd_data != '0));
    assign w_waddr = i_cmd.clr ? r_clr_addr : r_addr;
    assign w_wdata = i_cmd.clr ? '0 : r_rd_data + 1'b1;
    assign w_rd_ext = 64'(r_rd_data);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr <= i_c_re;
            r_ci <= i_c_im;
            r_re <= '0;
            r_im <= '0;
            r_n <= '0;
            r_addr <= AW'(i_bin_y) * AW'(GRID_X) + AW'(i_bin_x);
            r_oob <= (int'(i_bin_x) >= GRID_X) || (int'(i_bin_y) >= GRID_Y);
        end
        if (i_cmd.mul) begin
            r_rr <= r_re * r_re;
            r_ii <= r_im * r_im;
            r_ri <= r_re * r_im;
        end
        if (i_cmd.esc_step) begin
            r_n <= r_n + 1'b1;
            r_re <= w_re_next;
            r_im <= w_im_next;
        end
        if (i_cmd.rep_init) begin
            r_re <= '0;
            r_im <= '0;
            r_k <= '0;
        end
        if (i_cmd.rep_step) begin
            r_k <= r_k + 1'b1;
            r_re <= w_re_next;
            r_im <= w_im_next;
        end
        if (i_cmd.bin_mul) begin
            r_px <= 64'(w_mx[31:0]) * 64'(i_cfg.x_scale)
                  + (w_mx[32] ? {i_cfg.x_scale, 32'd0} : 64'd0);
            r_py <= 64'(w_my[31:0]) * 64'(i_cfg.y_scale)
                  + (w_my[32] ? {i_cfg.y_scale, 32'd0} : 64'd0);
            r_negx <= w_dx[32];
            r_negy <= w_dy[32];
        end
        if (i_cmd.bin_calc) begin
            r_hit <= w_hit;
            r_addr <= w_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_trace || i_cmd.out_read) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_trace) begin
            r_escaped <= (r_n <= 11'(i_cfg.iter_limit));
            r_iterations <= r_n;
            r_bin_count <= '0;
        end else if (i_cmd.out_read) begin
            r_escaped <= 1'b0;
            r_iterations <= '0;
            r_bin_count <= r_oob ? 32'd0 : w_rd_ext[31:0];
        end
    end

    assign o_status.is_read = (i_action == ACTION_READ);
    assign o_status.esc_cont = (w_mag <= 64'(i_cfg.radius_sq))
                            && (r_n <= 11'(i_cfg.iter_limit));
    assign o_status.escaped = (r_n <= 11'(i_cfg.iter_limit));
    assign o_status.rep_done = (r_k == r_n);
    assign o_status.clr_done = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_escaped = r_escaped;
    assign o_iterations = r_iterations;
    assign o_bin_count = r_bin_count;

endmodule

>>> rtl/core/escape_orbit_histogram.sv
`timescale 1ns / 1ps

// Buddhabrot orbit histogram. A trace request iterates z = z*z + c from zero;
// if the point escapes within the iteration limit, the orbit is replayed point
// by point, each point that lands in the active area updating one saturating
// bin counter by a read-modify-write of the histogram memory. A trace or a read
// request completes before the next request is accepted, and a result waits
// while the output still holds one that has not been taken. After reset the
// histogram memory is cleared one entry per cycle, during which no request is
// accepted; register writes are taken at any time.
module escape_orbit_histogram #(
    parameter int GRID_X = 256,
    parameter int GRID_Y = 256,
    parameter int COUNT_BITS = 32,
    parameter int FRAC_BITS = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    esh_in_if.sink      i_in,
    esh_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import esh_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_status w_status;

    esh_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    esh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    esh_datapath #(
        .GRID_X     (GRID_X),
        .GRID_Y     (GRID_Y),
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_action     (i_in.action),
        .i_c_re       (i_in.c_re),
        .i_c_im       (i_in.c_im),
        .i_bin_x      (i_in.bin_x),
        .i_bin_y      (i_in.bin_y),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_escaped    (o_out.escaped),
        .o_iterations (o_out.iterations),
        .o_bin_count  (o_out.bin_count)
    );

    assign i_in.ready = w_cmd.in_ready;

endmodule
